/* rtl/lcg48_pkg.sv */
package lcg48_pkg;

  localparam int unsigned StateW = 48;
  localparam int unsigned MultW = 35;
  localparam int unsigned BoundW = 31;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CntW = $clog2(MultW);
  localparam int unsigned DivCntW = $clog2(BoundW);

  localparam logic [MultW-1:0] LCG_MULT = 35'h5DEECE66D;
  localparam logic [StateW-1:0] LCG_ADD = 48'hB;
  localparam logic [StateW-1:0] LCG_RESET = 48'h5DEECE66D;

  typedef enum logic [2:0] {
    OP_SEED   = 3'd0,
    OP_INT    = 3'd1,
    OP_BOUND  = 3'd2,
    OP_LONG   = 3'd3,
    OP_BOOL   = 3'd4,
    OP_FLOAT  = 3'd5,
    OP_DOUBLE = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIV,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic start;
    logic load;
  } step_ctl_t;

endpackage

/* rtl/lcg48_random_generator_unit.sv */
// 48-bit linear congruential generator with the draw rules of the common
// library random class. An item on the input channel (op_i, seed_value_i,
// bound_i) is taken when in_valid_i is high and in_stall_o is low; exactly
// one result item (value_o) leaves on the output channel for each.
// Each state advance is a bit-serial shift-add multiply by the 35-bit
// multiplier constant. Seed and unused ops advance no state; int, bool and
// float take one state advance; long and double take two. A bounded int
// with a power-of-two bound takes one state advance; with another bound
// each attempt adds a pass through a bit-serial remainder unit, and a
// rejected draw repeats the attempt. A zero bound gives 0.
// One item is in work at a time. The result sits in an output register, so
// a new item is taken as soon as the previous one has reached it, even
// while the receiver stalls; the next result then waits until the output
// register is free.
// Reset loads the generator state with the scrambled zero seed and empties
// the output register.
module lcg48_random_generator_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [2:0]                            op_i,
  input  logic [lcg48_pkg::StateW-1:0]          seed_value_i,
  input  logic [lcg48_pkg::BoundW-1:0]          bound_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [lcg48_pkg::ValueW-1:0]   value_o
);
  import lcg48_pkg::*;

  ctl_state_e        state_q, state_d;
  op_e               op_q, op_d;
  logic [BoundW-1:0] bound_q, bound_d;
  logic [31:0]       hi_q, hi_d;
  logic [BoundW-1:0] u_q, u_d;
  logic              idx_q, idx_d;
  logic [ValueW-1:0] res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] value_q, value_d;

  step_ctl_t         step_ctl;
  logic              step_done;
  logic [StateW-1:0] lcg;
  logic              div_start;
  logic              div_done;
  logic [BoundW-1:0] rem;

  logic [31:0]         draw32;
  logic [BoundW-1:0]   draw31;
  logic                pow2;
  logic [2*BoundW-1:0] prod;
  logic [31:0]         check;

  lcg48_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (step_ctl),
    .seed_i  (seed_value_i),
    .done_o  (step_done),
    .state_o (lcg)
  );

  lcg48_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (draw31),
    .den_i   (bound_q),
    .done_o  (div_done),
    .rem_o   (rem)
  );

  assign draw32 = lcg[StateW-1:StateW-32];
  assign draw31 = lcg[StateW-1:StateW-BoundW];
  assign pow2   = (bound_q & (bound_q - 1'b1)) == '0;
  assign prod   = bound_q * draw31;
  // A draw is rejected when u - r + bound - 1 wraps negative in 32 bits.
  assign check  = {1'b0, u_q} - {1'b0, rem} + {1'b0, bound_q} - 32'd1;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    bound_d     = bound_q;
    hi_d        = hi_q;
    u_d         = u_q;
    idx_d       = idx_q;
    res_d       = res_q;
    step_ctl    = '0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(op_i);
          bound_d = bound_i;
          idx_d   = 1'b0;
          res_d   = '0;
          case (op_e'(op_i))
            OP_SEED: begin
              step_ctl.load = 1'b1;
              state_d       = ST_FINISH;
            end
            OP_INT, OP_LONG, OP_BOOL, OP_FLOAT, OP_DOUBLE: begin
              step_ctl.start = 1'b1;
              state_d        = ST_DRAW;
            end
            OP_BOUND: begin
              if (bound_i == '0) begin
                state_d = ST_FINISH;
              end else begin
                step_ctl.start = 1'b1;
                state_d        = ST_DRAW;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_DRAW: begin
        if (step_done) begin
          state_d = ST_FINISH;
          case (op_q)
            OP_INT: begin
              res_d = {{32{draw32[31]}}, draw32};
            end
            OP_LONG, OP_DOUBLE: begin
              if (!idx_q) begin
                hi_d           = draw32;
                idx_d          = 1'b1;
                step_ctl.start = 1'b1;
                state_d        = ST_DRAW;
              end else if (op_q == OP_LONG) begin
                res_d = {hi_q, 32'd0} + {{32{draw32[31]}}, draw32};
              end else begin
                res_d = {11'd0, hi_q[31:6], lcg[StateW-1:StateW-27]};
              end
            end
            OP_BOOL: begin
              res_d = {63'd0, lcg[StateW-1]};
            end
            OP_FLOAT: begin
              res_d = {40'd0, lcg[StateW-1:StateW-24]};
            end
            OP_BOUND: begin
              u_d = draw31;
              if (pow2) begin
                res_d = {33'd0, prod[2*BoundW-1:BoundW]};
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (check[31]) begin
            step_ctl.start = 1'b1;
            state_d        = ST_DRAW;
          end else begin
            res_d   = {33'd0, rem};
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          value_d     = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    bound_q <= bound_d;
    hi_q    <= hi_d;
    u_q     <= u_d;
    res_q   <= res_d;
    value_q <= value_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

/* rtl/lcg48_step.sv */
module lcg48_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lcg48_pkg::step_ctl_t           ctl_i,
  input  logic [lcg48_pkg::StateW-1:0]   seed_i,
  output logic                           done_o,
  output logic [lcg48_pkg::StateW-1:0]   state_o
);
  import lcg48_pkg::*;

  logic [StateW-1:0] state_q, state_d;
  logic [StateW-1:0] acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StateW-1:0] acc_next;

  // One multiplier bit per cycle, most significant first (Horner form).
  always_comb begin
    acc_next = {acc_q[StateW-2:0], 1'b0};
    if (LCG_MULT[cnt_q]) begin
      acc_next = acc_next + state_q;
    end
    if (cnt_q == '0) begin
      acc_next = acc_next + LCG_ADD;
    end
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      acc_d = acc_next;
      if (cnt_q == '0) begin
        state_d = acc_next;
        busy_d  = 1'b0;
        done_d  = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end else if (ctl_i.load) begin
      state_d = seed_i ^ StateW'(LCG_MULT);
    end else if (ctl_i.start) begin
      acc_d  = '0;
      cnt_d  = CntW'(MultW - 1);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LCG_RESET;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o  = done_q;
  assign state_o = state_q;

endmodule

/* rtl/lcg48_div.sv */
module lcg48_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lcg48_pkg::BoundW-1:0]   num_i,
  input  logic [lcg48_pkg::BoundW-1:0]   den_i,
  output logic                           done_o,
  output logic [lcg48_pkg::BoundW-1:0]   rem_o
);
  import lcg48_pkg::*;

  logic [BoundW-1:0]  num_q, num_d;
  logic [BoundW-1:0]  den_q, den_d;
  logic [BoundW-1:0]  rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BoundW:0]    trial;
  logic [BoundW:0]    diff;

  // Restoring division, one numerator bit per cycle.
  assign trial = {rem_q, num_q[BoundW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      num_d = {num_q[BoundW-2:0], 1'b0};
      rem_d = diff[BoundW] ? trial[BoundW-1:0] : diff[BoundW-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end else if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = DivCntW'(BoundW - 1);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
